>>> hw/rtl/sha256_pkg.sv
package sha256_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned BlkWords = 16;
    localparam int unsigned Rounds   = 64;

    localparam logic [WordW-1:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WordW-1:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LastBlkLimit = 6'd56;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic logic [WordW-1:0] big_s0(input logic [WordW-1:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WordW-1:0] big_s1(input logic [WordW-1:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WordW-1:0] sml_s0(input logic [WordW-1:0] x);
        sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WordW-1:0] sml_s1(input logic [WordW-1:0] x);
        sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> hw/rtl/sha256_ram.sv
module sha256_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/sha256_stream_hasher.sv
// SHA-256 hasher for a byte stream.
// Input channel (i_valid/o_ready): i_op selects absorb (one message byte in
// i_data_byte) or finish. Output channel (o_valid/i_ready): after a finish,
// eight digest words, word 0 first, o_last_word high on word 7.
// Absorbed bytes are packed into words and written to a 16-word block RAM.
// The 64th byte of a block starts a compression: the block is streamed
// from the RAM into the schedule register, then 64 rounds run at one per
// cycle, and finally the working variables are folded into the hash.
// A finish runs one or two such compressions (two when 56 or more bytes are
// pending), then presents the eight words, one per cycle when not stalled.
// While a compression runs or digest words wait, o_ready is low; a stalled
// receiver simply holds the block on the current word. No byte is taken
// while a block is compressed, so the round loop and the RAM read-out set the rate.
// After the last word transfers, the hash returns to the initial values.
// Reset (synchronous, active low) restores the initial hash, clears the
// byte and bit counts and returns to idle; the block RAM is not cleared.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha256_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        BK_DATA = 2'd0,
        BK_PAD  = 2'd1,
        BK_ZLEN = 2'd2
    } t_blk;

    t_state r_state, n_state;
    t_blk   r_blk, n_blk;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_bits, n_bits;
    logic [4:0]  r_ld, n_ld;
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_oidx, n_oidx;
    logic [31:0] r_h [8];
    logic [31:0] r_wk [8];
    logic [31:0] r_w [16];
    logic [31:0] r_part;

    logic        in_acc, out_acc;
    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata, ram_rdata;
    logic [31:0] byte_word, pad_word, ld_word, new_w, t1, t2;
    logic [3:0]  ld_idx, nw;
    logic [1:0]  bp;
    logic        final_pad;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    assign nw = r_cnt[5:2];
    assign bp = r_cnt[1:0];
    assign final_pad = (r_cnt < LastBlkLimit);
    assign ld_idx = r_ld[3:0] - 4'd1;

    // current partial word with the new byte placed at its lane
    always_comb begin
        byte_word = r_part;
        pad_word  = '0;
        for (int k = 0; k < 4; k++) begin
            if (k == bp) begin
                byte_word[(3-k)*8 +: 8] = i_data_byte;
                pad_word[(3-k)*8 +: 8]  = PadByte;
            end else if (k < bp) begin
                pad_word[(3-k)*8 +: 8]  = r_part[(3-k)*8 +: 8];
            end
        end
    end

    assign ram_we    = in_acc && (i_op == OP_ABSORB) && (bp == 2'd3);
    assign ram_waddr = nw;
    assign ram_wdata = byte_word;

    sha256_ram #(.WIDTH(32), .DEPTH(16)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ld[3:0]),
        .o_rdata (ram_rdata)
    );

    // word fed into the schedule during read-out, with padding applied
    always_comb begin
        ld_word = '0;
        case (r_blk)
            BK_DATA: ld_word = ram_rdata;
            BK_PAD: begin
                if (ld_idx < nw) begin
                    ld_word = ram_rdata;
                end else if (ld_idx == nw) begin
                    ld_word = pad_word;
                end
                if (final_pad && ld_idx == 4'd14) begin
                    ld_word = r_bits[63:32];
                end else if (final_pad && ld_idx == 4'd15) begin
                    ld_word = r_bits[31:0];
                end
            end
            BK_ZLEN: begin
                if (ld_idx == 4'd14) begin
                    ld_word = r_bits[63:32];
                end else if (ld_idx == 4'd15) begin
                    ld_word = r_bits[31:0];
                end
            end
            default: ld_word = '0;
        endcase
    end

    assign new_w = sml_s1(r_w[14]) + r_w[9] + sml_s0(r_w[1]) + r_w[0];
    assign t1 = r_wk[7] + big_s1(r_wk[4]) + ((r_wk[4] & r_wk[5]) ^ (~r_wk[4] & r_wk[6]))
              + RoundK[r_rnd] + r_w[0];
    assign t2 = big_s0(r_wk[0])
              + ((r_wk[0] & r_wk[1]) ^ (r_wk[0] & r_wk[2]) ^ (r_wk[1] & r_wk[2]));

    always_comb begin
        n_state = r_state;
        n_blk   = r_blk;
        n_cnt   = r_cnt;
        n_bits  = r_bits;
        n_ld    = r_ld;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ld = '0;
                    if (i_op == OP_ABSORB) begin
                        n_cnt  = r_cnt + 6'd1;
                        n_bits = r_bits + 64'd8;
                        if (r_cnt == 6'd63) begin
                            n_blk   = BK_DATA;
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_blk   = BK_PAD;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_ld = r_ld + 5'd1;
                if (r_ld == 5'd16) begin
                    n_rnd   = '0;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_ld = '0;
                if (r_blk == BK_DATA) begin
                    n_state = S_IDLE;
                end else if (r_blk == BK_PAD && !final_pad) begin
                    n_blk   = BK_ZLEN;
                    n_state = S_LOAD;
                end else begin
                    n_oidx  = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_cnt   = '0;
                        n_bits  = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_blk   <= BK_DATA;
            r_cnt   <= '0;
            r_bits  <= '0;
            r_ld    <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            for (int k = 0; k < 8; k++) begin
                r_h[k] <= InitHash[k];
            end
        end else begin
            r_state <= n_state;
            r_blk   <= n_blk;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
            r_ld    <= n_ld;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            if (r_state == S_FOLD) begin
                for (int k = 0; k < 8; k++) begin
                    r_h[k] <= r_h[k] + r_wk[k];
                end
            end else if (r_state == S_OUT && out_acc && r_oidx == 3'd7) begin
                for (int k = 0; k < 8; k++) begin
                    r_h[k] <= InitHash[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_op == OP_ABSORB) begin
            r_part <= byte_word;
        end
        if ((r_state == S_LOAD && r_ld != 5'd0) || r_state == S_ROUND) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k+1];
            end
            r_w[15] <= (r_state == S_LOAD) ? ld_word : new_w;
        end
        if (r_state == S_LOAD && r_ld == 5'd16) begin
            for (int k = 0; k < 8; k++) begin
                r_wk[k] <= r_h[k];
            end
        end else if (r_state == S_ROUND) begin
            r_wk[7] <= r_wk[6];
            r_wk[6] <= r_wk[5];
            r_wk[5] <= r_wk[4];
            r_wk[4] <= r_wk[3] + t1;
            r_wk[3] <= r_wk[2];
            r_wk[2] <= r_wk[1];
            r_wk[1] <= r_wk[0];
            r_wk[0] <= t1 + t2;
        end
    end
endmodule

>>> verif/sha256_stream_hasher_tb.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;
    import sha256_pkg::*;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_byte_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = OP_ABSORB;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_stream_hasher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always #10 i_clk = ~i_clk;

    localparam logic [31:0] HashK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] HashIv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // predictor state
    logic [31:0] chain_h [8];
    logic [7:0]  msg_bytes [64];
    logic [5:0]  n_pending;
    logic [63:0] bit_len;

    t_byte_item  send_q [$];
    t_digest_out digest_q [$];

    int  n_errors = 0;
    int  n_msgs = 0;
    int  n_words = 0;
    int  idle_cycles = 0;
    bit  stim_done = 1'b0;
    bit  quiet_mode = 1'b0;
    bit  hold_rx = 1'b0;

    // acceptance (valid and ready) at the last rising edge decides whether the held item moved
    logic o_ready_q = 1'b0;

    function automatic logic [31:0] rr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress(input logic [31:0] blk [16]);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++) w[t] = blk[t];
        for (int t = 16; t < 64; t++) begin
            w[t] = (rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & f) ^ (~e & g))
               + HashK[t] + w[t];
            t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) chain_h[i] = HashIv[i];
        n_pending = '0;
        bit_len = '0;
    endtask

    task automatic hash_step(input t_byte_item it);
        logic [31:0] blk [16];
        logic [7:0]  v;
        if (it.op == OP_ABSORB) begin
            msg_bytes[n_pending] = it.data;
            bit_len += 64'd8;
            if (n_pending == 6'd63) begin
                for (int i = 0; i < 16; i++)
                    blk[i] = {msg_bytes[4*i], msg_bytes[4*i+1],
                              msg_bytes[4*i+2], msg_bytes[4*i+3]};
                compress(blk);
            end
            n_pending = n_pending + 6'd1;
        end else begin
            for (int p = 0; p < 64; p++) begin
                v = (p < n_pending) ? msg_bytes[p] : (p == n_pending) ? 8'h80 : 8'h00;
                blk[p/4][8*(3 - p%4) +: 8] = v;
            end
            if (n_pending >= 6'd56) begin
                compress(blk);
                for (int i = 0; i < 16; i++) blk[i] = '0;
            end
            blk[14] = bit_len[63:32];
            blk[15] = bit_len[31:0];
            compress(blk);
            for (int i = 0; i < 8; i++)
                digest_q.push_back('{word: chain_h[i], idx: 3'(i), last: (i == 7)});
            restart_hash();
        end
    endtask

    task automatic add_msg(input int len, input bit all_ff);
        for (int i = 0; i < len; i++)
            send_q.push_back('{op: OP_ABSORB,
                               data: all_ff ? 8'hff : (i == 0 ? 8'h00 : 8'($urandom))});
        send_q.push_back('{op: OP_FINISH, data: 8'($urandom)});
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_q) begin
                if (send_q.size() > 0 && (quiet_mode || $urandom_range(99) >= 18)) begin
                    i_valid     <= 1'b1;
                    i_op        <= send_q[0].op;
                    i_data_byte <= send_q[0].data;
                    void'(send_q.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= !hold_rx && (quiet_mode || $urandom_range(99) >= 18);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        o_ready_q <= i_valid && o_ready;
        if (i_rst_n) begin
            idle_cycles = idle_cycles + 1;
            if (i_valid && o_ready) begin
                idle_cycles = 0;
                hash_step('{op: i_op, data: i_data_byte});
                if (i_op == OP_FINISH) n_msgs = n_msgs + 1;
            end
            if (o_valid && i_ready) begin
                idle_cycles = 0;
                n_words = n_words + 1;
                if (digest_q.size() == 0) begin
                    $error("digest word with no expectation: %h", o_digest_word);
                    n_errors = n_errors + 1;
                end else begin
                    if (o_digest_word !== digest_q[0].word) begin
                        $error("digest_word: expected %h, got %h",
                               digest_q[0].word, o_digest_word);
                        n_errors = n_errors + 1;
                    end
                    if (o_word_index !== digest_q[0].idx) begin
                        $error("word_index: expected %0d, got %0d",
                               digest_q[0].idx, o_word_index);
                        n_errors = n_errors + 1;
                    end
                    if (o_last_word !== digest_q[0].last) begin
                        $error("last_word: expected %0d, got %0d",
                               digest_q[0].last, o_last_word);
                        n_errors = n_errors + 1;
                    end
                    void'(digest_q.pop_front());
                end
            end
        end
    end

    initial begin
        restart_hash();
        for (int i = 0; i < 64; i++) msg_bytes[i] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, ignored data, short messages, all-ones bytes
        send_q.push_back('{op: OP_FINISH, data: 8'hff});
        add_msg(1, 1'b1);
        add_msg(3, 1'b0);
        add_msg(5, 1'b1);
        add_msg(2, 1'b0);
        add_msg(1, 1'b0);
        wait (send_q.size() == 0);

        // receiver held off while sender keeps offering: digest words wait and input stalls
        hold_rx = 1'b1;
        add_msg(2, 1'b0);
        add_msg(1, 1'b1);
        repeat (300) @(posedge i_clk);
        hold_rx = 1'b0;

        // full block plus pad block, then one-block limit, with no idling
        wait (send_q.size() == 0);
        quiet_mode = 1'b1;
        add_msg(64, 1'b0);
        add_msg(55, 1'b0);
        wait (send_q.size() == 0);
        quiet_mode = 1'b0;

        // length no longer fits: extra pad block
        add_msg(56, 1'b1);

        // random messages, mostly short
        for (int m = 0; m < 8; m++) begin
            add_msg($urandom_range(0, ($urandom_range(9) == 0) ? 70 : 12), 1'b0);
        end

        wait (send_q.size() == 0 && !i_valid && digest_q.size() == 0);
        repeat (200) @(posedge i_clk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done || idle_cycles >= 5000);
        if (stim_done) begin
            $display("Hashed %0d messages (empty, pad-boundary, multi-block, random),",
                     n_msgs);
            $display("checked %0d digest words under random stalls and backpressure.",
                     n_words);
            if (n_errors == 0 && digest_q.size() == 0) begin
                $display("All tests passed");
            end else begin
                $display("Some tests failed");
            end
        end else begin
            $display("Timeout: no transfer for 5000 cycles");
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
